FILE: src/lru_pkg.sv
// Package for the keyed LRU store: field widths, codes and shared types.
// No dependencies.
package lru_pkg;
  localparam int unsigned MaxEntries = 8;
  localparam int unsigned CapReset = 5;
  localparam int unsigned KeyW = 16;
  localparam int unsigned ValW = 32;
  localparam int unsigned CapW = 4;
  localparam int unsigned QDepth = 2;

  typedef enum logic [1:0] {
    KIND_ACK = 2'd0,
    KIND_ENTRY = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  localparam logic REQ_PUT = 1'b0;
  localparam logic REQ_DUMP = 1'b1;

  typedef struct packed {
    logic req_type;
    logic [KeyW-1:0] client_id;
    logic [ValW-1:0] msg_handle;
  } cmd_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [KeyW-1:0] entry_key;
    logic [ValW-1:0] entry_value;
    logic key_was_present;
    logic did_evict;
    logic last_of_run;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DUMP = 2'd1,
    ST_OUT = 2'd2
  } state_t;
endpackage

FILE: src/lru_if.sv
// Valid/ready channel interfaces for the keyed LRU store.
// Depends on lru_pkg.
interface lru_in_if;
  logic valid;
  logic ready;
  logic req_type;
  logic [lru_pkg::KeyW-1:0] client_id;
  logic [lru_pkg::ValW-1:0] msg_handle;
  modport source(output valid, req_type, client_id, msg_handle, input ready);
  modport sink(input valid, req_type, client_id, msg_handle, output ready);
endinterface

interface lru_out_if;
  logic valid;
  logic ready;
  logic [1:0] result_kind;
  logic [lru_pkg::KeyW-1:0] entry_key;
  logic [lru_pkg::ValW-1:0] entry_value;
  logic key_was_present;
  logic did_evict;
  logic last_of_run;
  modport source(output valid, result_kind, entry_key, entry_value, key_was_present,
                 did_evict, last_of_run, input ready);
  modport sink(input valid, result_kind, entry_key, entry_value, key_was_present,
               did_evict, last_of_run, output ready);
endinterface

interface lru_cfg_if;
  logic valid;
  logic ready;
  logic [lru_pkg::CapW-1:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

FILE: src/lru_front.sv
// Front end: accepts request words into a short queue.
// Depends on lru_pkg.
module lru_front (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  lru_pkg::cmd_t in_cmd,
  output logic q_valid,
  input  logic q_pop,
  output lru_pkg::cmd_t q_cmd
);
  lru_pkg::cmd_t mem_r [lru_pkg::QDepth];
  logic rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic push;

  assign in_ready = (cnt_r != 2'(lru_pkg::QDepth));
  assign push = in_valid && in_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = mem_r[rd_r];
  assign rd_nxt = rd_r ^ q_pop;
  assign wr_nxt = wr_r ^ push;
  assign cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= 1'b0;
      wr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r <= rd_nxt;
      wr_r <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wr_r] <= in_cmd;
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'(lru_pkg::QDepth))
    else $error("queue overfilled");
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("pop of empty queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_pop) |=> cnt_r == $past(cnt_r) + 2'd1)
    else $error("fill count lost a push");
endmodule

FILE: src/lru_back.sv
// Back end: slot registers with recency ranks, executes put and dump.
// Depends on lru_pkg.
module lru_back #(
  parameter int unsigned MAX_ENTRIES = lru_pkg::MaxEntries
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  output logic q_pop,
  input  lru_pkg::cmd_t q_cmd,
  input  logic cfg_we,
  input  logic [lru_pkg::CapW-1:0] cfg_data,
  output logic idle,
  output logic res_valid,
  input  logic res_ready,
  output lru_pkg::res_t res
);
  localparam int unsigned RW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  logic [lru_pkg::KeyW-1:0] key_r [MAX_ENTRIES];
  logic [lru_pkg::KeyW-1:0] key_nxt [MAX_ENTRIES];
  logic [lru_pkg::ValW-1:0] val_r [MAX_ENTRIES];
  logic [lru_pkg::ValW-1:0] val_nxt [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] vld_r, vld_nxt;
  logic [RW-1:0] rank_r [MAX_ENTRIES];
  logic [RW-1:0] rank_nxt [MAX_ENTRIES];
  logic [lru_pkg::CapW-1:0] cap_r, cap_nxt;
  lru_pkg::state_t st_r, st_nxt;
  logic [RW-1:0] walk_r, walk_nxt;
  lru_pkg::res_t res_r, res_nxt;
  logic res_valid_r, res_valid_nxt;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cap_eff;
  logic [CW-1:0] cap_new_eff;
  logic do_put, do_dump, emit_dump;
  logic hit;
  logic [RW-1:0] hit_s, free_s, walk_s, vic_s;
  logic walk_hit;
  logic evict;
  logic [RW-1:0] put_s;
  logic [RW-1:0] hit_rank;

  function automatic logic [CW-1:0] eff(input logic [lru_pkg::CapW-1:0] c);
    if (c == '0) return CW'(1);
    if (32'(c) > MAX_ENTRIES) return CW'(MAX_ENTRIES);
    return CW'(c);
  endfunction

  assign cap_eff = eff(cap_r);
  assign cap_new_eff = eff(cfg_data);

  always_comb begin
    cnt = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) cnt = cnt + CW'(vld_r[i]);
  end

  // hit search, dump walk, victim and lowest free slot
  always_comb begin
    hit = 1'b0; hit_s = '0; free_s = '0; walk_hit = 1'b0; walk_s = '0; vic_s = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (vld_r[i] && key_r[i] == q_cmd.client_id) begin
        hit = 1'b1; hit_s = RW'(i);
      end
      if (vld_r[i] && rank_r[i] == walk_r) begin
        walk_hit = 1'b1; walk_s = RW'(i);
      end
      if (vld_r[i] && CW'(rank_r[i]) == cnt - CW'(1)) vic_s = RW'(i);
      if (!vld_r[i]) free_s = RW'(i);
    end
    evict = !hit && (cnt >= cap_eff);
  end

  assign do_put = (st_r == lru_pkg::ST_IDLE) && q_valid && q_cmd.req_type == lru_pkg::REQ_PUT;
  assign do_dump = (st_r == lru_pkg::ST_IDLE) && q_valid && q_cmd.req_type == lru_pkg::REQ_DUMP;
  assign emit_dump = (st_r == lru_pkg::ST_DUMP) && (!res_valid_r || res_ready);

  // new entry lands in the lowest slot that is free once the old one is gone
  always_comb begin
    hit_rank = rank_r[hit_s];
    put_s = free_s;
    if (hit && (hit_s < free_s || vld_r == '1)) put_s = hit_s;
    if (evict && (vic_s < free_s || vld_r == '1)) put_s = vic_s;
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      lru_pkg::ST_IDLE: begin
        if (do_put) st_nxt = lru_pkg::ST_OUT;
        else if (do_dump) st_nxt = (cnt == '0) ? lru_pkg::ST_OUT : lru_pkg::ST_DUMP;
      end
      lru_pkg::ST_DUMP: begin
        if (emit_dump && CW'(walk_r) + CW'(1) == cnt) st_nxt = lru_pkg::ST_OUT;
      end
      lru_pkg::ST_OUT: begin
        if (res_ready) st_nxt = lru_pkg::ST_IDLE;
      end
      default: st_nxt = lru_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    key_nxt = key_r;
    val_nxt = val_r;
    vld_nxt = vld_r;
    rank_nxt = rank_r;
    cap_nxt = cap_r;
    walk_nxt = walk_r;
    res_nxt = res_r;
    res_valid_nxt = res_valid_r && !res_ready;
    if (cfg_we) begin
      cap_nxt = cfg_data;
      // drop every entry ranked at or beyond the new capacity
      for (int i = 0; i < MAX_ENTRIES; i++)
        if (CW'(rank_r[i]) >= cap_new_eff) vld_nxt[i] = 1'b0;
    end
    if (do_put) begin
      for (int i = 0; i < MAX_ENTRIES; i++)
        if (vld_r[i] && (!hit || rank_r[i] < hit_rank)) rank_nxt[i] = rank_r[i] + RW'(1);
      if (evict) vld_nxt[vic_s] = 1'b0;
      if (hit) vld_nxt[hit_s] = 1'b0;
      vld_nxt[put_s] = 1'b1;
      rank_nxt[put_s] = '0;
      key_nxt[put_s] = q_cmd.client_id;
      val_nxt[put_s] = q_cmd.msg_handle;
      res_valid_nxt = 1'b1;
      res_nxt = '{lru_pkg::KIND_ACK, evict ? key_r[vic_s] : '0,
                  evict ? val_r[vic_s] : '0, hit, evict, 1'b1};
    end
    if (do_dump) begin
      walk_nxt = '0;
      if (cnt == '0) begin
        res_valid_nxt = 1'b1;
        res_nxt = '{lru_pkg::KIND_EMPTY, '0, '0, 1'b0, 1'b0, 1'b1};
      end
    end
    if (emit_dump) begin
      res_valid_nxt = 1'b1;
      res_nxt = '{lru_pkg::KIND_ENTRY, key_r[walk_s], val_r[walk_s], 1'b0, 1'b0,
                  (CW'(walk_r) + CW'(1) == cnt)};
      walk_nxt = walk_r + RW'(1);
    end
  end

  assign q_pop = do_put || do_dump;
  assign res = res_r;
  assign res_valid = res_valid_r;
  assign idle = (st_r == lru_pkg::ST_IDLE) && !res_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= lru_pkg::ST_IDLE;
      vld_r <= '0;
      cap_r <= lru_pkg::CapW'(lru_pkg::CapReset);
      res_valid_r <= 1'b0;
      res_r <= '0;
      walk_r <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) rank_r[i] <= '0;
    end else begin
      st_r <= st_nxt;
      vld_r <= vld_nxt;
      cap_r <= cap_nxt;
      res_valid_r <= res_valid_nxt;
      res_r <= res_nxt;
      walk_r <= walk_nxt;
      rank_r <= rank_nxt;
      key_r <= key_nxt;
      val_r <= val_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == lru_pkg::ST_DUMP) |-> walk_hit) else $error("dump rank missing");
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt <= cap_eff) else $error("count above capacity");
  assert property (@(posedge clk) disable iff (!rst_n)
    do_put |=> res_valid_r) else $error("put gave no acknowledge");
  assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> idle) else $error("capacity written while busy");
endmodule

FILE: src/lru_keyed_latest_store_core.sv
// Top level of the keyed LRU store: front queue and back-end slot engine.
// Depends on lru_pkg, lru_if, lru_front and lru_back.
// A put or a dump of an empty store, once at the head of the queue, does
// its match-and-rank update, then waits until its word is taken; a dump
// of n entries starts, gives one word per cycle while the receiver takes
// them, then holds the last word until taken. A two-word queue parts the
// input from the slot engine, so requests are taken while results wait.
// The capacity register takes a write only while the engine is idle, the
// queue is empty and no request is offered; a lower capacity drops the
// least recent entries at once without a word.
module lru_keyed_latest_store_core #(
  parameter int unsigned MAX_ENTRIES = lru_pkg::MaxEntries
) (
  input logic clk,
  input logic rst_n,
  lru_in_if.sink in,
  lru_out_if.source out,
  lru_cfg_if.sink cfg
);
  lru_pkg::cmd_t in_cmd, q_cmd;
  lru_pkg::res_t res;
  logic q_valid, q_pop;
  logic back_idle;
  logic idle_ok;

  assign in_cmd = '{in.req_type, in.client_id, in.msg_handle};
  // hold configuration until nothing is in flight
  assign idle_ok = back_idle && !q_valid && !in.valid;
  assign cfg.ready = idle_ok;

  lru_front u_front (
    .clk, .rst_n,
    .in_valid(in.valid), .in_ready(in.ready), .in_cmd,
    .q_valid, .q_pop, .q_cmd
  );

  lru_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
    .clk, .rst_n,
    .q_valid, .q_pop, .q_cmd,
    .cfg_we(cfg.valid && cfg.ready), .cfg_data(cfg.data),
    .idle(back_idle),
    .res_valid(out.valid), .res_ready(out.ready), .res
  );

  assign out.result_kind = res.result_kind;
  assign out.entry_key = res.entry_key;
  assign out.entry_value = res.entry_value;
  assign out.key_was_present = res.key_was_present;
  assign out.did_evict = res.did_evict;
  assign out.last_of_run = res.last_of_run;
endmodule

FILE: tb/sv/lru_tb_if.sv
`timescale 1ns / 1ps
// Testbench-side types: the result word the predictor expects.
// Depends on lru_pkg.
package lru_tb_pkg;
  typedef struct packed {
    logic [1:0] kind;
    logic [lru_pkg::KeyW-1:0] key;
    logic [lru_pkg::ValW-1:0] val;
    logic present;
    logic evict;
    logic last;
  } res_word_t;
endpackage

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Testbench for lru_keyed_latest_store_core: directed table then random puts and dumps,
// checked word by word against an LRU predictor. Depends on lru_pkg, lru_if, lru_tb_pkg.
module testbench;
  localparam int unsigned WatchLimit = 4000;
  localparam int unsigned NEnt = lru_pkg::MaxEntries;

  typedef struct {
    logic is_cfg;
    logic [lru_pkg::CapW-1:0] cap;
    logic req_type;
    logic [lru_pkg::KeyW-1:0] client_id;
    logic [lru_pkg::ValW-1:0] msg_handle;
    logic has_exp;
    lru_tb_pkg::res_word_t exp_word;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lru_in_if  in_ch();
  lru_out_if out_ch();
  lru_cfg_if cfg_ch();

  lru_keyed_latest_store_core u_dut (
    .clk  (clk),
    .rst_n(rst_n),
    .in   (in_ch.sink),
    .out  (out_ch.source),
    .cfg  (cfg_ch.sink)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [lru_pkg::KeyW-1:0] slot_key_m [NEnt];
  logic [lru_pkg::ValW-1:0] slot_val_m [NEnt];
  logic                     slot_vld_m [NEnt];
  int unsigned              slot_rank_m[NEnt];
  logic [lru_pkg::CapW-1:0] cap_reg;

  lru_tb_pkg::res_word_t pending_words[$];
  int unsigned n_errors = 0;
  int unsigned idle_cycles = 0;
  bit tail_quiet = 1'b0;
  bit hold_long = 1'b0;

  function automatic int unsigned eff_cap();
    if (cap_reg == 0) return 1;
    if (cap_reg > NEnt) return NEnt;
    return int'(cap_reg);
  endfunction

  function automatic int unsigned live_count();
    int unsigned n;
    n = 0;
    for (int i = 0; i < NEnt; i++) if (slot_vld_m[i]) n++;
    return n;
  endfunction

  task automatic queue_word(input lru_tb_pkg::res_word_t w);
    pending_words = {pending_words, w};
  endtask

  task automatic lru_clear();
    for (int i = 0; i < NEnt; i++) begin
      slot_vld_m[i] = 1'b0;
      slot_rank_m[i] = 0;
      slot_key_m[i] = '0;
      slot_val_m[i] = '0;
    end
    cap_reg = lru_pkg::CapW'(lru_pkg::CapReset);
  endtask

  task automatic lru_set_cap(input logic [lru_pkg::CapW-1:0] c);
    cap_reg = c;
    for (int i = 0; i < NEnt; i++)
      if (slot_vld_m[i] && slot_rank_m[i] >= eff_cap()) slot_vld_m[i] = 1'b0;
  endtask

  // queue the words a request will produce and update the store
  task automatic lru_apply(input logic rq, input logic [lru_pkg::KeyW-1:0] k,
                           input logic [lru_pkg::ValW-1:0] v);
    int unsigned n;
    int unsigned r;
    lru_tb_pkg::res_word_t w;
    logic pres;
    logic ev;
    logic [lru_pkg::KeyW-1:0] ek;
    logic [lru_pkg::ValW-1:0] evv;
    if (rq == lru_pkg::REQ_DUMP) begin
      n = live_count();
      if (n == 0) begin
        w = '{lru_pkg::KIND_EMPTY, '0, '0, 1'b0, 1'b0, 1'b1};
        queue_word(w);
        return;
      end
      for (int rr = 0; rr < n; rr++)
        for (int i = 0; i < NEnt; i++)
          if (slot_vld_m[i] && slot_rank_m[i] == rr) begin
            w = '{lru_pkg::KIND_ENTRY, slot_key_m[i], slot_val_m[i], 1'b0, 1'b0, rr + 1 == n};
            queue_word(w);
          end
      return;
    end
    pres = 1'b0; ev = 1'b0; ek = '0; evv = '0;
    for (int i = 0; i < NEnt; i++)
      if (!pres && slot_vld_m[i] && slot_key_m[i] == k) begin
        pres = 1'b1;
        r = slot_rank_m[i];
        slot_vld_m[i] = 1'b0;
        for (int j = 0; j < NEnt; j++)
          if (slot_vld_m[j] && slot_rank_m[j] > r) slot_rank_m[j]--;
      end
    n = live_count();
    if (n >= eff_cap() && n > 0)
      for (int i = 0; i < NEnt; i++)
        if (!ev && slot_vld_m[i] && slot_rank_m[i] == n - 1) begin
          ev = 1'b1;
          ek = slot_key_m[i];
          evv = slot_val_m[i];
          slot_vld_m[i] = 1'b0;
        end
    for (int i = 0; i < NEnt; i++) if (slot_vld_m[i]) slot_rank_m[i]++;
    for (int i = 0; i < NEnt; i++)
      if (!slot_vld_m[i]) begin
        slot_vld_m[i] = 1'b1;
        slot_key_m[i] = k;
        slot_val_m[i] = v;
        slot_rank_m[i] = 0;
        break;
      end
    w = '{lru_pkg::KIND_ACK, ek, evv, pres, ev, 1'b1};
    queue_word(w);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    n_errors++;
    $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
  endtask

  // sender side
  task automatic send_word(input logic rq, input logic [lru_pkg::KeyW-1:0] k,
                           input logic [lru_pkg::ValW-1:0] v);
    if (!tail_quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= rq;
    in_ch.client_id <= k;
    in_ch.msg_handle <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    lru_apply(rq, k, v);
  endtask

  task automatic drop_valid();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_cap(input logic [lru_pkg::CapW-1:0] c);
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= c;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    lru_set_cap(c);
    @(posedge clk);
  endtask

  // receiver side: ready with random bursts of stall, one long hold-off
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_long) begin
        out_ch.ready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_long = 1'b0;
      end else if (!tail_quiet && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
          || (cfg_ch.valid && cfg_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("testbench NOT OK");
        $finish;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_words.size() == 0) begin
          report_mismatch("unexpected word", 64'(out_ch.entry_key), 64'(0));
        end else begin
          lru_tb_pkg::res_word_t e;
          e = pending_words.pop_front();
          if (out_ch.result_kind !== e.kind)
            report_mismatch("kind", 64'(out_ch.result_kind), 64'(e.kind));
          if (out_ch.entry_key !== e.key)
            report_mismatch("key", 64'(out_ch.entry_key), 64'(e.key));
          if (out_ch.entry_value !== e.val)
            report_mismatch("value", 64'(out_ch.entry_value), 64'(e.val));
          if (out_ch.key_was_present !== e.present)
            report_mismatch("present", 64'(out_ch.key_was_present), 64'(e.present));
          if (out_ch.did_evict !== e.evict)
            report_mismatch("evict", 64'(out_ch.did_evict), 64'(e.evict));
          if (out_ch.last_of_run !== e.last)
            report_mismatch("last", 64'(out_ch.last_of_run), 64'(e.last));
        end
      end
    end
  end

  dir_row_t dir_rows[$];

  task automatic add_row(input dir_row_t r);
    dir_rows = {dir_rows, r};
  endtask

  function automatic dir_row_t row_put(input logic [lru_pkg::KeyW-1:0] k,
                                       input logic [lru_pkg::ValW-1:0] v);
    dir_row_t r;
    r = '{1'b0, '0, lru_pkg::REQ_PUT, k, v, 1'b0, '0};
    return r;
  endfunction

  function automatic dir_row_t row_dump();
    dir_row_t r;
    r = '{1'b0, '0, lru_pkg::REQ_DUMP, '0, '0, 1'b0, '0};
    return r;
  endfunction

  function automatic dir_row_t row_cap(input logic [lru_pkg::CapW-1:0] c);
    dir_row_t r;
    r = '{1'b1, c, lru_pkg::REQ_PUT, '0, '0, 1'b0, '0};
    return r;
  endfunction

  initial begin
    dir_row_t r;
    logic [lru_pkg::KeyW-1:0] k;
    in_ch.valid = 1'b0;
    in_ch.req_type = lru_pkg::REQ_PUT;
    in_ch.client_id = '0;
    in_ch.msg_handle = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    lru_clear();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; rows with a typed-in word are checked against it too
    r = row_dump();
    r.has_exp = 1'b1;
    r.exp_word = '{lru_pkg::KIND_EMPTY, '0, '0, 1'b0, 1'b0, 1'b1};
    add_row(r);
    r = row_put(16'h0000, 32'h0000_0000);
    r.has_exp = 1'b1;
    r.exp_word = '{lru_pkg::KIND_ACK, '0, '0, 1'b0, 1'b0, 1'b1};
    add_row(r);
    add_row(row_put(16'hffff, 32'hffff_ffff));
    add_row(row_put(16'h0000, 32'h1234_5678));
    add_row(row_put(16'h5555, 32'haaaa_aaaa));
    add_row(row_put(16'haaaa, 32'h5555_5555));
    add_row(row_put(16'h0001, 32'h8000_0000));
    add_row(row_put(16'h8000, 32'h0000_0001));
    add_row(row_dump());
    add_row(row_cap(4'd8));
    for (int i = 0; i < 4; i++)
      add_row(row_put(lru_pkg::KeyW'(16'h0100 + i), lru_pkg::ValW'(32'hc000_0000 + i)));
    add_row(row_dump());
    add_row(row_cap(4'd2));
    add_row(row_dump());
    add_row(row_cap(4'd0));
    add_row(row_put(16'h0200, 32'h0000_0200));
    add_row(row_put(16'h0200, 32'h0000_0201));
    add_row(row_dump());
    add_row(row_cap(4'd15));
    add_row(row_dump());

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_cap(dir_rows[i].cap);
      end else begin
        if (dir_rows[i].has_exp) begin
          drop_valid();
          while (pending_words.size() != 0) @(posedge clk);
        end
        send_word(dir_rows[i].req_type, dir_rows[i].client_id, dir_rows[i].msg_handle);
        if (dir_rows[i].has_exp && pending_words[$] != dir_rows[i].exp_word)
          report_mismatch("table", 64'(pending_words[$]), 64'(dir_rows[i].exp_word));
      end
    end

    // long hold-off on the receiver while words keep coming
    hold_long = 1'b1;
    for (int i = 0; i < 12; i++)
      send_word(lru_pkg::REQ_PUT, lru_pkg::KeyW'($urandom_range(0, 15)),
                lru_pkg::ValW'($urandom()));

    for (int ph = 0; ph < 4; ph++) begin
      write_cap(lru_pkg::CapW'(ph == 0 ? 1 : ph == 1 ? 8 : ph == 2 ? $urandom_range(0, 15) : 5));
      for (int i = 0; i < 47; i++) begin
        if (ph == 3 && i > 30) tail_quiet = 1'b1;
        if ($urandom_range(0, 5) == 0) begin
          send_word(lru_pkg::REQ_DUMP, lru_pkg::KeyW'($urandom()), lru_pkg::ValW'($urandom()));
        end else begin
          // mostly a small key pool to hit replacement, sometimes full range
          k = ($urandom_range(0, 4) == 0) ? lru_pkg::KeyW'($urandom())
                                           : lru_pkg::KeyW'($urandom_range(0, 11));
          send_word(lru_pkg::REQ_PUT, k, lru_pkg::ValW'($urandom()));
        end
      end
    end
    send_word(lru_pkg::REQ_DUMP, '0, '0);
    drop_valid();

    while (pending_words.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (n_errors == 0 && pending_words.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule

FILE: sim.f
src/lru_pkg.sv
src/lru_if.sv
src/lru_front.sv
src/lru_back.sv
src/lru_keyed_latest_store_core.sv
tb/sv/lru_tb_if.sv
tb/sv/testbench.sv
